### hdl/bbss_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sample store.
`default_nettype none
package bbss_pkg;

  localparam int SLOTS      = 32;
  localparam int DIMS       = 5;
  localparam int NORMALS    = 5;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int VAL_DEPTH  = SLOTS * DIMS;
  localparam int VAL_AW     = $clog2(VAL_DEPTH);
  localparam int DIM_W      = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 24;
  localparam int CNT_W      = 7;

  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_GEN,
    CMD_CLEAN,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_BEFORE_HEAD,
    ST_PAST_END
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_CUR,
    SEL_FREE
  } slot_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_GEN_LINK,
    OP_GEN_TIME,
    OP_CLN_LINK,
    OP_CLN_TIME,
    OP_FREE,
    OP_MUL_VAR,
    OP_DIV_VAR,
    OP_SQRT,
    OP_CAP_S,
    OP_RD_VAL_M,
    OP_RD_VAL_P,
    OP_DIFF,
    OP_MUL_MEAN,
    OP_DIV_MEAN,
    OP_MUL_NOISE,
    OP_SUM,
    OP_WR_TIME,
    OP_WR_LINK,
    OP_CPY_FIN,
    OP_RD_CUR,
    OP_CAP_VAL,
    OP_CPY_WR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    slot_sel_t sel;
    status_t   status;
    logic      zero;
  } emit_t;

  typedef struct packed {
    dp_op_t op;
    emit_t  emit;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic before_head;
    logic hit;
    logic link_self;
    logic nx_gt_t;
    logic cur_ge_t;
    logic step_last;
    logic full;
    logic has_ip;
    logic dim_last;
    logic ds_done;
    logic cur_zero;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### hdl/bbss_divsqrt.sv
// Shared iterative unit: 64/32 restoring divide and 48-bit integer square root.
`default_nettype none
module bbss_divsqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_div,
  input  logic        start_sqrt,
  input  logic [63:0] num,
  input  logic [31:0] den,
  input  logic [47:0] rad,
  output logic [31:0] res,
  output logic        done
);
  import bbss_pkg::*;

  logic             busy_r;
  logic             sqrt_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      num_r;
  logic [31:0]      den_r;
  logic [31:0]      rem_r;
  logic [31:0]      q_r;
  logic [47:0]      x_r;
  logic [47:0]      root_r;
  logic [47:0]      bit_r;

  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic        div_ge;
  logic [47:0] rb;
  logic        sq_ge;

  assign trial     = {rem_r, num_r[63]};
  assign trial_sub = trial - {1'b0, den_r};
  assign div_ge    = trial >= {1'b0, den_r};
  assign rb        = root_r + bit_r;
  assign sq_ge     = x_r >= rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sqrt_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_div) begin
        busy_r <= 1'b1;
        sqrt_r <= 1'b0;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (start_sqrt) begin
        busy_r <= 1'b1;
        sqrt_r <= 1'b1;
        cnt_r  <= CNT_W'(SQRT_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r && !sqrt_r) begin
      rem_r <= div_ge ? trial_sub[31:0] : trial[31:0];
      num_r <= {num_r[62:0], 1'b0};
      q_r   <= {q_r[30:0], div_ge};
    end
    if (start_sqrt) begin
      x_r    <= rad;
      root_r <= '0;
      bit_r  <= 48'd1 << 46;
    end else if (busy_r && sqrt_r) begin
      if (sq_ge) begin
        x_r    <= x_r - rb;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign res  = sqrt_r ? root_r[31:0] : q_r;
  assign done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divsqrt done without a running operation");

endmodule
`default_nettype wire

### hdl/bbss_datapath.sv
// Datapath: slot memories, list walk registers, bridge arithmetic and result register.
`default_nettype none
module bbss_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bbss_pkg::ctl_t      ctl,
  output bbss_pkg::sts_t      sts,
  input  logic [1:0]          in_cmd,
  input  logic [31:0]         in_at_time,
  input  logic signed [15:0]  in_normal [bbss_pkg::NORMALS],
  input  logic                out_stall,
  output logic                out_valid,
  output logic [4:0]          out_slot_index,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_value [bbss_pkg::NORMALS]
);
  import bbss_pkg::*;

  logic [31:0]        time_mem [SLOTS];
  logic [IDX_W-1:0]   link_mem [SLOTS];
  logic signed [31:0] val_mem  [VAL_DEPTH];

  logic [31:0]        head_time_r;
  logic [IDX_W-1:0]   head_link_r;
  logic [SLOTS-1:0]   used_r;
  logic               zero_r;
  logic               out_valid_r;

  logic [31:0]        time_rd_r;
  logic               time_head_r;
  logic [IDX_W-1:0]   link_rd_r;
  logic               link_head_r;
  logic signed [31:0] val_rd_r;
  logic               val_zero_r;

  cmd_t               cmd_r;
  logic [31:0]        t_r;
  logic signed [15:0] nrm_r [NORMALS];
  logic [IDX_W-1:0]   cur_r;
  logic [31:0]        cur_time_r;
  logic [IDX_W-1:0]   im_r;
  logic [31:0]        im_time_r;
  logic [IDX_W-1:0]   ip_r;
  logic [31:0]        ip_time_r;
  logic               has_ip_r;
  logic [SLOTS-1:0]   visited_r;
  logic [IDX_W-1:0]   step_r;
  logic [IDX_W-1:0]   e_r;
  logic [31:0]        dt_r;
  logic [31:0]        dt2_r;
  logic [31:0]        span_r;
  logic [63:0]        prod_r;
  logic [23:0]        s_r;
  logic [DIM_W-1:0]   dim_r;
  logic signed [31:0] base_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic signed [40:0] nprod_r;
  logic signed [32:0] offset_r;
  logic signed [31:0] res_val_r [DIMS];
  logic [IDX_W-1:0]   out_slot_r;
  status_t            out_status_r;
  logic signed [31:0] out_val_r [NORMALS];

  logic [IDX_W-1:0]   link_rdata;
  logic [31:0]        time_rdata;
  logic signed [31:0] val_rdata;
  logic [IDX_W-1:0]   free_idx;
  logic               free_any;
  logic [IDX_W-1:0]   rslot;
  logic [VAL_AW-1:0]  val_raddr;
  logic [VAL_AW-1:0]  val_eaddr;
  logic signed [32:0] diff;
  logic signed [32:0] mag_full;
  logic signed [32:0] q_signed;
  logic signed [40:0] nround;
  logic signed [41:0] vsum;
  logic signed [31:0] vsat;
  logic [31:0]        ds_res;
  logic               ds_done;
  logic               last_dim;

  assign link_rdata = link_head_r ? head_link_r : link_rd_r;
  assign time_rdata = time_head_r ? head_time_r : time_rd_r;
  assign val_rdata  = val_zero_r ? 32'sd0 : val_rd_r;
  assign last_dim   = dim_r == DIM_W'(DIMS - 1);

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int k = SLOTS - 1; k >= 1; k--) begin
      if (!used_r[k]) begin
        free_idx = IDX_W'(k);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    case (ctl.op)
      OP_RD_VAL_M: rslot = im_r;
      OP_RD_VAL_P: rslot = ip_r;
      default:     rslot = cur_r;
    endcase
  end

  assign val_raddr = VAL_AW'(rslot) * VAL_AW'(DIMS) + VAL_AW'(dim_r);
  assign val_eaddr = VAL_AW'(e_r) * VAL_AW'(DIMS) + VAL_AW'(dim_r);

  assign diff     = 33'(val_rdata) - 33'(base_r);
  assign mag_full = diff[32] ? -diff : diff;
  assign q_signed = neg_r ? -$signed({1'b0, ds_res}) : $signed({1'b0, ds_res});
  assign nround   = nprod_r + 41'sd2048;
  assign vsum     = 42'(base_r) + 42'(offset_r) + 42'(nround >>> 12);

  always_comb begin
    if (vsum > 42'sd2147483647) begin
      vsat = 32'sh7fffffff;
    end else if (vsum < -42'sd2147483648) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = vsum[31:0];
    end
  end

  bbss_divsqrt u_divsqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_div  (ctl.op == OP_DIV_VAR || ctl.op == OP_DIV_MEAN),
    .start_sqrt (ctl.op == OP_SQRT),
    .num        (prod_r),
    .den        (span_r),
    .rad        (has_ip_r ? {ds_res, 16'h0000} : {dt_r, 16'h0000}),
    .res        (ds_res),
    .done       (ds_done)
  );

  // memories and their registered read ports
  always_ff @(posedge clk) begin
    time_rd_r   <= time_mem[link_rdata];
    time_head_r <= link_rdata == '0;
    link_rd_r   <= link_mem[cur_r];
    link_head_r <= cur_r == '0;
    val_rd_r    <= val_mem[val_raddr];
    val_zero_r  <= zero_r && rslot == '0;
    if (ctl.op == OP_SUM) begin
      val_mem[val_eaddr] <= vsat;
    end else if (ctl.op == OP_CPY_WR) begin
      val_mem[VAL_AW'(dim_r)] <= val_rdata;
    end
    if (ctl.op == OP_WR_TIME) begin
      time_mem[e_r] <= t_r;
      link_mem[e_r] <= has_ip_r ? ip_r : e_r;
    end else if (ctl.op == OP_WR_LINK && im_r != '0) begin
      link_mem[im_r] <= e_r;
    end
  end

  // store control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_time_r <= '0;
      head_link_r <= '0;
      used_r      <= SLOTS'(1);
      zero_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        OP_INIT: begin
          head_time_r <= t_r;
          head_link_r <= '0;
          used_r      <= SLOTS'(1);
          zero_r      <= 1'b1;
        end
        OP_WR_TIME: used_r[e_r] <= 1'b1;
        OP_WR_LINK: begin
          if (im_r == '0) begin
            head_link_r <= e_r;
          end
        end
        OP_CPY_FIN: begin
          head_time_r <= cur_time_r;
          head_link_r <= (link_rdata == cur_r) ? '0 : link_rdata;
          used_r      <= (used_r & ~visited_r & ~(SLOTS'(1) << cur_r)) | SLOTS'(1);
          zero_r      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // request and walk registers, arithmetic
  always_ff @(posedge clk) begin
    case (ctl.op) inside
      OP_LOAD: begin
        cmd_r      <= cmd_t'(in_cmd);
        t_r        <= in_at_time;
        nrm_r      <= in_normal;
        cur_r      <= '0;
        cur_time_r <= head_time_r;
        im_r       <= '0;
        im_time_r  <= head_time_r;
        ip_r       <= '0;
        ip_time_r  <= '0;
        has_ip_r   <= 1'b0;
        visited_r  <= '0;
        step_r     <= '0;
        dim_r      <= '0;
      end
      OP_GEN_LINK: begin
        if (cur_time_r < t_r) begin
          im_r      <= cur_r;
          im_time_r <= cur_time_r;
        end
      end
      OP_GEN_TIME: begin
        if (time_rdata > t_r) begin
          ip_r      <= link_rdata;
          ip_time_r <= time_rdata;
          has_ip_r  <= 1'b1;
        end else begin
          cur_r      <= link_rdata;
          cur_time_r <= time_rdata;
          step_r     <= step_r + 1'b1;
        end
      end
      OP_CLN_LINK: begin
        visited_r[cur_r] <= 1'b1;
        cur_r            <= link_rdata;
        step_r           <= step_r + 1'b1;
      end
      OP_CLN_TIME: cur_time_r <= time_rdata;
      OP_FREE: begin
        e_r    <= free_idx;
        dt_r   <= t_r - im_time_r;
        dt2_r  <= ip_time_r - t_r;
        span_r <= ip_time_r - im_time_r;
      end
      OP_MUL_VAR:  prod_r <= 64'(dt_r) * 64'(dt2_r);
      OP_CAP_S:    s_r <= ds_res[23:0];
      OP_RD_VAL_P: base_r <= val_rdata;
      OP_DIFF: begin
        neg_r <= diff[32];
        mag_r <= mag_full[31:0];
      end
      OP_MUL_MEAN: prod_r <= 64'(mag_r) * 64'(dt_r);
      OP_MUL_NOISE: begin
        nprod_r  <= $signed({1'b0, s_r}) * nrm_r[dim_r];
        offset_r <= has_ip_r ? q_signed : 33'sd0;
      end
      OP_SUM: begin
        res_val_r[dim_r] <= vsat;
        if (!last_dim) begin
          dim_r <= dim_r + 1'b1;
        end
      end
      OP_CAP_VAL, OP_CPY_WR: begin
        res_val_r[dim_r] <= val_rdata;
        if (!last_dim) begin
          dim_r <= dim_r + 1'b1;
        end
      end
      OP_EMIT: begin
        case (ctl.emit.sel)
          SEL_CUR:  out_slot_r <= cur_r;
          SEL_FREE: out_slot_r <= e_r;
          default:  out_slot_r <= '0;
        endcase
        out_status_r <= ctl.emit.status;
        for (int d = 0; d < NORMALS; d++) begin
          if (d < DIMS && !ctl.emit.zero) begin
            out_val_r[d] <= res_val_r[d];
          end else begin
            out_val_r[d] <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts.cmd         = cmd_r;
  assign sts.before_head = t_r < head_time_r;
  assign sts.hit         = cur_time_r == t_r;
  assign sts.link_self   = link_rdata == cur_r;
  assign sts.nx_gt_t     = time_rdata > t_r;
  assign sts.cur_ge_t    = cur_time_r >= t_r;
  assign sts.step_last   = step_r == IDX_W'(SLOTS - 1);
  assign sts.full        = !free_any;
  assign sts.has_ip      = has_ip_r;
  assign sts.dim_last    = last_dim;
  assign sts.ds_done     = ds_done;
  assign sts.cur_zero    = cur_r == '0;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_slot_index = 5'(out_slot_r);
  assign out_status     = out_status_r;
  assign out_value      = out_val_r;

  a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[0])
    else $error("head slot marked free");

  a_new_slot_not_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == OP_WR_TIME |-> e_r != '0 && !used_r[e_r])
    else $error("new sample written to head or occupied slot");

  a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == OP_SUM || ctl.op == OP_CAP_VAL || ctl.op == OP_CPY_WR |->
      dim_r <= DIM_W'(DIMS - 1))
    else $error("dimension counter out of range");

endmodule
`default_nettype wire

### hdl/bbss_ctrl.sv
// Controller: sequences the walk, bridge arithmetic, clean copy and result hand-off.
`default_nettype none
module bbss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bbss_pkg::sts_t sts,
  output bbss_pkg::ctl_t ctl
);
  import bbss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_GLINK_W, S_GLINK, S_GTIME, S_GFREE,
    S_GMULV, S_GDIVV, S_GWDIVV, S_GSQRT, S_GWSQRT,
    S_GRDM, S_GRDP, S_GDIFF, S_GMULM, S_GDIVM, S_GWDIVM, S_GNOISE, S_GSUM,
    S_GWRT, S_GWRL,
    S_CCHK, S_CTIME, S_CPRD, S_CPWR,
    S_HRD, S_HCAP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  emit_t  emit_r, emit_nxt;

  localparam emit_t EMIT_HEAD = '{sel: SEL_ZERO, status: ST_OK, zero: 1'b0};
  localparam emit_t EMIT_CUR  = '{sel: SEL_CUR, status: ST_OK, zero: 1'b0};
  localparam emit_t EMIT_NEW  = '{sel: SEL_FREE, status: ST_OK, zero: 1'b0};
  localparam emit_t EMIT_INIT = '{sel: SEL_ZERO, status: ST_OK, zero: 1'b1};

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    ctl.op    = OP_NONE;
    ctl.emit  = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.cmd)
          CMD_INIT: begin
            ctl.op    = OP_INIT;
            emit_nxt  = EMIT_INIT;
            state_nxt = S_EMIT;
          end
          CMD_GEN: begin
            if (sts.before_head) begin
              emit_nxt  = '{sel: SEL_ZERO, status: ST_BEFORE_HEAD, zero: 1'b1};
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_GLINK;
            end
          end
          CMD_CLEAN: state_nxt = S_CCHK;
          default: begin
            emit_nxt  = EMIT_CUR;
            state_nxt = S_HRD;
          end
        endcase
      end
      S_GLINK_W: state_nxt = S_GLINK;
      S_GLINK: begin
        if (sts.hit) begin
          emit_nxt  = EMIT_CUR;
          state_nxt = S_HRD;
        end else begin
          ctl.op    = OP_GEN_LINK;
          state_nxt = sts.link_self ? S_GFREE : S_GTIME;
        end
      end
      S_GTIME: begin
        ctl.op = OP_GEN_TIME;
        if (sts.nx_gt_t || sts.step_last) begin
          state_nxt = S_GFREE;
        end else begin
          state_nxt = S_GLINK_W;
        end
      end
      S_GFREE: begin
        if (sts.full) begin
          emit_nxt  = '{sel: SEL_ZERO, status: ST_FULL, zero: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          ctl.op    = OP_FREE;
          state_nxt = sts.has_ip ? S_GMULV : S_GSQRT;
        end
      end
      S_GMULV: begin
        ctl.op    = OP_MUL_VAR;
        state_nxt = S_GDIVV;
      end
      S_GDIVV: begin
        ctl.op    = OP_DIV_VAR;
        state_nxt = S_GWDIVV;
      end
      S_GWDIVV: begin
        if (sts.ds_done) begin
          state_nxt = S_GSQRT;
        end
      end
      S_GSQRT: begin
        ctl.op    = OP_SQRT;
        state_nxt = S_GWSQRT;
      end
      S_GWSQRT: begin
        if (sts.ds_done) begin
          ctl.op    = OP_CAP_S;
          state_nxt = S_GRDM;
        end
      end
      S_GRDM: begin
        ctl.op    = OP_RD_VAL_M;
        state_nxt = S_GRDP;
      end
      S_GRDP: begin
        ctl.op    = OP_RD_VAL_P;
        state_nxt = sts.has_ip ? S_GDIFF : S_GNOISE;
      end
      S_GDIFF: begin
        ctl.op    = OP_DIFF;
        state_nxt = S_GMULM;
      end
      S_GMULM: begin
        ctl.op    = OP_MUL_MEAN;
        state_nxt = S_GDIVM;
      end
      S_GDIVM: begin
        ctl.op    = OP_DIV_MEAN;
        state_nxt = S_GWDIVM;
      end
      S_GWDIVM: begin
        if (sts.ds_done) begin
          state_nxt = S_GNOISE;
        end
      end
      S_GNOISE: begin
        ctl.op    = OP_MUL_NOISE;
        state_nxt = S_GSUM;
      end
      S_GSUM: begin
        ctl.op    = OP_SUM;
        state_nxt = sts.dim_last ? S_GWRT : S_GRDM;
      end
      S_GWRT: begin
        ctl.op    = OP_WR_TIME;
        state_nxt = S_GWRL;
      end
      S_GWRL: begin
        ctl.op    = OP_WR_LINK;
        emit_nxt  = EMIT_NEW;
        state_nxt = S_EMIT;
      end
      S_CCHK: begin
        if (sts.cur_ge_t) begin
          if (sts.cur_zero) begin
            emit_nxt  = EMIT_CUR;
            state_nxt = S_HRD;
          end else begin
            ctl.op    = OP_CPY_FIN;
            emit_nxt  = EMIT_HEAD;
            state_nxt = S_CPRD;
          end
        end else if (sts.link_self || sts.step_last) begin
          emit_nxt  = '{sel: SEL_ZERO, status: ST_PAST_END, zero: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          ctl.op    = OP_CLN_LINK;
          state_nxt = S_CTIME;
        end
      end
      S_CTIME: begin
        ctl.op    = OP_CLN_TIME;
        state_nxt = S_CCHK;
      end
      S_CPRD: begin
        ctl.op    = OP_RD_CUR;
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        ctl.op    = OP_CPY_WR;
        state_nxt = sts.dim_last ? S_EMIT : S_CPRD;
      end
      S_HRD: begin
        ctl.op    = OP_RD_CUR;
        state_nxt = S_HCAP;
      end
      S_HCAP: begin
        ctl.op    = OP_CAP_VAL;
        state_nxt = sts.dim_last ? S_EMIT : S_HRD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= EMIT_HEAD;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule
`default_nettype wire

### hdl/brownian_bridge_sample_store_unit.sv
// Top level of the Brownian-bridge sample store.
//
// Input channel (in_valid/in_stall): one request carries a command, a Q16.16
// time and five Q4.12 normals. Output channel (out_valid/out_stall): one result
// per request with slot, status and five Q16.16 sample values.
// One request is worked on at a time; in_stall is low only when the controller
// is idle. The result register lets the next request enter while a result waits.
// A bridge between two samples runs through the shared one-bit-per-cycle
// divider (six divides) and the square root.
// Each walk step waits on the link and time memory reads.
// Reset (synchronous, rst_n low) leaves one zero sample at time 0 in slot 0.
// A stalled result holds out_valid and its fields until taken; a finished
// request waits in the controller until the result register is free.
`default_nettype none
module brownian_bridge_sample_store_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_at_time,
  input  logic signed [15:0] in_normal_0,
  input  logic signed [15:0] in_normal_1,
  input  logic signed [15:0] in_normal_2,
  input  logic signed [15:0] in_normal_3,
  input  logic signed [15:0] in_normal_4,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_slot_index,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_0,
  output logic signed [31:0] out_value_1,
  output logic signed [31:0] out_value_2,
  output logic signed [31:0] out_value_3,
  output logic signed [31:0] out_value_4
);
  import bbss_pkg::*;

  ctl_t               ctl;
  sts_t               sts;
  logic signed [15:0] normals [NORMALS];
  logic signed [31:0] values  [NORMALS];

  assign normals[0] = in_normal_0;
  assign normals[1] = in_normal_1;
  assign normals[2] = in_normal_2;
  assign normals[3] = in_normal_3;
  assign normals[4] = in_normal_4;

  assign out_value_0 = values[0];
  assign out_value_1 = values[1];
  assign out_value_2 = values[2];
  assign out_value_3 = values[3];
  assign out_value_4 = values[4];

  bbss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  bbss_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_at_time     (in_at_time),
    .in_normal      (normals),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_slot_index (out_slot_index),
    .out_status     (out_status),
    .out_value      (values)
  );

endmodule
`default_nettype wire

### dv/brownian_bridge_sample_store_unit_test.sv
// Self-checking testbench for the Brownian-bridge sample store: random and directed requests.
`timescale 1ns / 100ps
`default_nettype none
module brownian_bridge_sample_store_unit_test;
  import bbss_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        at_time;
    logic signed [15:0] n0, n1, n2, n3, n4;
  } request_t;

  typedef struct packed {
    logic [4:0]         slot;
    logic [1:0]         status;
    logic signed [31:0] v0, v1, v2, v3, v4;
  } sample_out_t;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [31:0] in_at_time = '0;
  logic signed [15:0] in_normal_0 = '0, in_normal_1 = '0, in_normal_2 = '0;
  logic signed [15:0] in_normal_3 = '0, in_normal_4 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] out_slot_index;
  logic [1:0] out_status;
  logic signed [31:0] out_value_0, out_value_1, out_value_2, out_value_3, out_value_4;

  brownian_bridge_sample_store_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // store model
  logic [31:0]        m_time [SLOTS];
  logic [4:0]         m_link [SLOTS];
  logic               m_used [SLOTS];
  logic signed [31:0] m_val  [SLOTS][DIMS];

  request_t    pending_requests[$];
  sample_out_t expected_samples[$];
  int mismatches = 0, results_seen = 0, accepted = 0;
  int n_ok = 0, n_full = 0, n_before = 0, n_past = 0, n_bridge = 0;
  int send_idle = 19, recv_idle = 68;

  function automatic u64_t root64(u64_t x);
    u64_t r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scaled_noise(u64_t s, logic signed [15:0] n);
    longint q;
    q = longint'(s) * longint'(n) + 2048;
    if (q >= 0) return q >>> 12;
    return -longint'((u64_t'(-q) + 4095) >> 12);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void wipe_store(logic [31:0] t);
    for (int i = 0; i < SLOTS; i++) begin
      m_time[i] = '0;
      m_link[i] = '0;
      m_used[i] = 1'b0;
      for (int d = 0; d < DIMS; d++) m_val[i][d] = '0;
    end
    m_used[0] = 1'b1;
    m_time[0] = t;
  endfunction

  function automatic sample_out_t sample_at(int slot, status_t st, bit vals);
    sample_out_t r;
    r = '0;
    r.slot = slot[4:0];
    r.status = st;
    if (vals) begin
      r.v0 = m_val[slot][0]; r.v1 = m_val[slot][1]; r.v2 = m_val[slot][2];
      r.v3 = m_val[slot][3]; r.v4 = m_val[slot][4];
    end
    return r;
  endfunction

  function automatic sample_out_t store_step(request_t rq);
    logic [31:0] t, tm, dt, dt2;
    int idx, im, ip, fr, nx, p;
    bit has_ip, reached;
    u64_t s, span, var_q, mag, q;
    longint base, v, diff;
    logic signed [15:0] nrm[5];
    t = rq.at_time;
    case (cmd_t'(rq.cmd))
      CMD_INIT: begin
        wipe_store(t);
        return sample_at(0, ST_OK, 1);
      end
      CMD_GEN: begin
        if (t < m_time[0]) return sample_at(0, ST_BEFORE_HEAD, 0);
        idx = 0; im = 0; ip = 0; has_ip = 0;
        for (int k = 0; k < SLOTS; k++) begin
          nx = m_link[idx];
          if (m_time[idx] == t) return sample_at(idx, ST_OK, 1);
          if (m_time[idx] < t) im = idx;
          if (nx != idx && m_time[nx] > t) begin
            ip = nx; has_ip = 1; break;
          end
          if (nx == idx) break;
          idx = nx;
        end
        fr = 0;
        for (int k = 1; k < SLOTS; k++)
          if (!m_used[k]) begin
            fr = k; break;
          end
        if (fr == 0) return sample_at(0, ST_FULL, 0);
        tm = m_time[im];
        dt = t - tm;
        span = 0;
        if (has_ip) begin
          dt2 = m_time[ip] - t;
          span = m_time[ip] - tm;
          var_q = (u64_t'(dt) * dt2) / span;
          s = root64(var_q << 16);
          n_bridge++;
        end else s = root64(u64_t'(dt) << 16);
        nrm = '{rq.n0, rq.n1, rq.n2, rq.n3, rq.n4};
        for (int d = 0; d < DIMS; d++) begin
          base = m_val[im][d];
          v = base;
          if (has_ip) begin
            diff = longint'(m_val[ip][d]) - base;
            mag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
            q = (mag * dt) / span;
            v += (diff < 0) ? -longint'(q) : longint'(q);
          end
          v += scaled_noise(s, nrm[d]);
          m_val[fr][d] = clamp32(v);
        end
        m_time[fr] = t;
        m_used[fr] = 1'b1;
        m_link[fr] = has_ip ? ip[4:0] : fr[4:0];
        m_link[im] = fr[4:0];
        return sample_at(fr, ST_OK, 1);
      end
      CMD_CLEAN: begin
        idx = 0; reached = 0;
        for (int k = 0; k < SLOTS; k++) begin
          if (m_time[idx] >= t) begin
            reached = 1; break;
          end
          nx = m_link[idx];
          if (nx == idx) break;
          idx = nx;
        end
        if (!reached) return sample_at(0, ST_PAST_END, 0);
        if (idx != 0) begin
          p = 0;
          for (int k = 0; k < SLOTS && p != idx; k++) begin
            m_used[p] = 1'b0;
            p = m_link[p];
          end
          nx = m_link[idx];
          m_time[0] = m_time[idx];
          for (int d = 0; d < DIMS; d++) m_val[0][d] = m_val[idx][d];
          m_link[0] = (nx == idx) ? 5'd0 : nx[4:0];
          m_used[0] = 1'b1;
          m_used[idx] = 1'b0;
        end
        return sample_at(0, ST_OK, 1);
      end
      default: return sample_at(0, ST_OK, 1);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_normal();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed(16'($urandom_range(0, 16383))) - 16'sd8192);
    endcase
  endfunction

  function automatic void push_req(cmd_t c, logic [31:0] t, bit extreme_n = 0);
    request_t r;
    r.cmd = c;
    r.at_time = t;
    if (extreme_n) begin
      r.n0 = 16'sh7fff; r.n1 = 16'sh8000; r.n2 = 16'sh0000;
      r.n3 = 16'shffff; r.n4 = 16'sh0001;
    end else begin
      r.n0 = rand_normal(); r.n1 = rand_normal(); r.n2 = rand_normal();
      r.n3 = rand_normal(); r.n4 = rand_normal();
    end
    pending_requests.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(store_step(pending_requests.pop_front()));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          r = pending_requests[0];
          in_valid <= 1'b1;
          in_cmd <= r.cmd;
          in_at_time <= r.at_time;
          in_normal_0 <= r.n0; in_normal_1 <= r.n1; in_normal_2 <= r.n2;
          in_normal_3 <= r.n3; in_normal_4 <= r.n4;
        end else in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    sample_out_t got, exp_s;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_slot_index, out_status, out_value_0, out_value_1, out_value_2,
             out_value_3, out_value_4};
      results_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_s = expected_samples.pop_front();
        case (status_t'(exp_s.status))
          ST_OK: n_ok++;
          ST_FULL: n_full++;
          ST_BEFORE_HEAD: n_before++;
          default: n_past++;
        endcase
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_s, got);
        end
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("[brownian_bridge_sample_store_unit] ERROR");
      $finish;
    end
  end

  task automatic random_phase(int n);
    logic [31:0] now;
    int i;
    i = 0;
    now = 0;
    while (i < n) begin
      // episode: init, then appends at increasing times, bridges, lookups, cleans, random requests
      now = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
      push_req(CMD_INIT, now); i++;
      for (int j = 0; j < $urandom_range(4, 40) && i < n; j++, i++) begin
        case ($urandom_range(0, 19)) inside
          [0:6]: begin
            now = now + $urandom_range(1, 32'h0004_0000);
            push_req(CMD_GEN, now);
          end
          [7:11]: push_req(CMD_GEN, now - $urandom_range(0, 32'h0008_0000));
          12: push_req(CMD_GEN, now);
          [13:14]: push_req(CMD_CLEAN, now - $urandom_range(0, 32'h0004_0000));
          15: push_req(CMD_CLEAN, now + $urandom_range(1, 100));
          16: push_req(CMD_NOP, $urandom);
          17: push_req(CMD_GEN, $urandom);
          default: push_req(cmd_t'($urandom_range(0, 3)), $urandom);
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_samples.size() != 0) @(posedge clk);
  endtask

  initial begin
    wipe_store(32'd0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    push_req(CMD_NOP, 32'hffff_ffff, 1);
    push_req(CMD_GEN, 32'd0, 1);
    push_req(CMD_GEN, 32'h0001_0000, 1);
    push_req(CMD_GEN, 32'h0000_8000, 1);
    push_req(CMD_GEN, 32'h0000_8000);
    push_req(CMD_CLEAN, 32'h0000_4000);
    push_req(CMD_CLEAN, 32'hffff_ffff);
    push_req(CMD_CLEAN, 32'd0);
    push_req(CMD_INIT, 32'h8000_0000);
    push_req(CMD_GEN, 32'h7fff_ffff);
    push_req(CMD_GEN, 32'hffff_ffff, 1);
    push_req(CMD_GEN, 32'hc000_0000, 1);
    push_req(CMD_CLEAN, 32'hffff_ffff);
    push_req(CMD_INIT, 32'd0);
    for (int k = 1; k <= 32; k++) push_req(CMD_GEN, k * 32'h0001_0000, 1);
    push_req(CMD_GEN, 32'h0000_0100);
    push_req(CMD_CLEAN, 32'h0010_0000);
    push_req(CMD_GEN, 32'h0000_8000);
    wait_drained();
    random_phase(480);
    wait_drained();
    send_idle = 68; recv_idle = 19;
    random_phase(480);
    wait_drained();
    send_idle = 0; recv_idle = 0;
    random_phase(480);
    wait_drained();
    repeat (600) @(posedge clk);
    $display("run: %0d requests, %0d results (ok %0d, bridge %0d, full %0d,",
             accepted, results_seen, n_ok, n_bridge, n_full);
    $display("     before head %0d, past end %0d), %0d mismatches",
             n_before, n_past, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("[brownian_bridge_sample_store_unit] OK");
    else
      $display("[brownian_bridge_sample_store_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
